>>> src/a4k_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a4k_pkg: shared types, constants and functions for the four-key AES core
// S-box, GF doubling, round helpers and the payload structs.
// ----------------------------------------------------------------------------
package a4k_pkg;

    localparam int MaxKeys    = 4;
    localparam int NumKeysDef = 4;
    localparam int NumRounds  = 10;

    typedef logic [127:0] t_block;

    typedef struct packed {
        logic [63:0] plaintext_hi;
        logic [63:0] plaintext_lo;
        logic [63:0] key3_hi;
        logic [63:0] key3_lo;
        logic [63:0] key2_hi;
        logic [63:0] key2_lo;
        logic [63:0] key1_hi;
        logic [63:0] key1_lo;
        logic [63:0] key0_hi;
        logic [63:0] key0_lo;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  key_index;
        logic [63:0] ciphertext_lo;
        logic [63:0] ciphertext_hi;
        logic        last;
    } t_out_word;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] gf2(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // round constant for round r (1..10)
    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] c;
        c = 8'h01;
        for (int i = 1; i < 10; i++) begin
            if (i < int'(r)) c = gf2(c);
        end
        return c;
    endfunction

    function automatic t_block next_key(input t_block rk, input logic [7:0] rc);
        t_block n;
        n[7:0]   = rk[7:0]   ^ sbox(rk[111:104]) ^ rc;
        n[15:8]  = rk[15:8]  ^ sbox(rk[119:112]);
        n[23:16] = rk[23:16] ^ sbox(rk[127:120]);
        n[31:24] = rk[31:24] ^ sbox(rk[103:96]);
        for (int k = 4; k < 16; k++) n[8*k +: 8] = rk[8*k +: 8] ^ n[8*(k-4) +: 8];
        return n;
    endfunction

    function automatic t_block round_fn(input t_block s, input logic do_mix);
        t_block t;
        t_block m;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[8*(r+4*c) +: 8] = sbox(s[8*(r + 4*((c+r) & 3)) +: 8]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[32*c +: 8];
            a1 = t[32*c+8 +: 8];
            a2 = t[32*c+16 +: 8];
            a3 = t[32*c+24 +: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            m[32*c +: 8]    = a0 ^ al ^ gf2(a0 ^ a1);
            m[32*c+8 +: 8]  = a1 ^ al ^ gf2(a1 ^ a2);
            m[32*c+16 +: 8] = a2 ^ al ^ gf2(a2 ^ a3);
            m[32*c+24 +: 8] = a3 ^ al ^ gf2(a3 ^ a0);
        end
        return do_mix ? m : t;
    endfunction

endpackage

>>> src/a4k_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a4k_if: valid/ready channel carrying one word of type T
// ----------------------------------------------------------------------------
interface a4k_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/a4k_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a4k_lane: unrolled AES-128 pipeline, one round and key step per stage
// Advances only when i_en; stage valid bits are kept by the caller.
// ----------------------------------------------------------------------------
module a4k_lane (
    input  logic            i_clk,
    input  logic            i_en,
    input  a4k_pkg::t_block i_pt,
    input  a4k_pkg::t_block i_key,
    output a4k_pkg::t_block o_ct
);
    import a4k_pkg::*;

    t_block r_s [NumRounds+1];
    t_block r_k [NumRounds+1];

    // stage 0: initial add round key; stage r: round r
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s[0] <= i_pt ^ i_key;
            r_k[0] <= i_key;
            for (int r = 1; r <= NumRounds; r++) begin
                r_k[r] <= next_key(r_k[r-1], rcon(4'(r)));
                r_s[r] <= round_fn(r_s[r-1], r != NumRounds)
                          ^ next_key(r_k[r-1], rcon(4'(r)));
            end
        end
    end

    assign o_ct = r_s[NumRounds];
endmodule

>>> src/a4k_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a4k_merge: serializes the lane results of one item onto the output channel
// Holds one finished item while the next one runs in the lanes.
// ----------------------------------------------------------------------------
module a4k_merge #(
    parameter int NUM_KEYS = a4k_pkg::NumKeysDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  a4k_pkg::t_block i_ct [NUM_KEYS],
    output logic            o_busy,
    a4k_if.source           o_out
);
    import a4k_pkg::*;

    localparam int IW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    t_block        r_ct [NUM_KEYS];
    logic          r_vld;
    logic [IW-1:0] r_idx;
    logic          w_at_last;

    assign w_at_last = (r_idx == IW'(NUM_KEYS - 1));

    // free again in the cycle the last word leaves, so the next item loads at once
    assign o_busy = r_vld && !(o_out.ready && w_at_last);

    // word sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else if (i_load) begin
            r_vld <= 1'b1;
            r_idx <= '0;
        end else if (r_vld && o_out.ready) begin
            if (w_at_last) r_vld <= 1'b0;
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_ct <= i_ct;
    end

    assign o_out.valid              = r_vld;
    assign o_out.data.key_index     = 2'(r_idx);
    assign o_out.data.ciphertext_lo = r_ct[r_idx][63:0];
    assign o_out.data.ciphertext_hi = r_ct[r_idx][127:64];
    assign o_out.data.last          = w_at_last;
endmodule

>>> src/aes128_encrypt_four_keys_core.sv
`timescale 1ns / 1ps
// An accepted word passes the pipeline stages (initial add round key, rounds
//   1 to 10) and the output hold; the item rate is set by the single output
//   channel that carries NUM_KEYS result words; lanes run the keys in parallel.
// Pipeline advances unless its final stage is full and the output hold is busy.
// Reset (synchronous, active low) clears the stage valid bits and output state.
// ----------------------------------------------------------------------------
// aes128_encrypt_four_keys_core: AES-128 of one block under NUM_KEYS keys
// Parallel lanes, one per key, feed a merging output stage.
// ----------------------------------------------------------------------------
module aes128_encrypt_four_keys_core #(
    parameter int NUM_KEYS = a4k_pkg::NumKeysDef
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    a4k_if.sink   i_in,
    a4k_if.source o_out
);
    import a4k_pkg::*;

    localparam int NS = NumRounds + 1;

    t_block    w_key [MaxKeys];
    t_block    w_ct  [NUM_KEYS];
    t_block    w_pt;
    logic [NS-1:0] r_vld;
    logic      w_busy, w_load, w_en;

    assign w_pt     = {i_in.data.plaintext_hi, i_in.data.plaintext_lo};
    assign w_key[0] = {i_in.data.key0_hi, i_in.data.key0_lo};
    assign w_key[1] = {i_in.data.key1_hi, i_in.data.key1_lo};
    assign w_key[2] = {i_in.data.key2_hi, i_in.data.key2_lo};
    assign w_key[3] = {i_in.data.key3_hi, i_in.data.key3_lo};

    // pipeline moves unless a finished item cannot enter the output hold
    assign w_load  = r_vld[NS-1] && !w_busy;
    assign w_en    = !r_vld[NS-1] || w_load;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_in.valid};
        end
    end

    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
        a4k_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_pt  (w_pt),
            .i_key (w_key[g]),
            .o_ct  (w_ct[g])
        );
    end

    a4k_merge #(.NUM_KEYS(NUM_KEYS)) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_ct    (w_ct),
        .o_busy  (w_busy),
        .o_out   (o_out)
    );

    // a result word only appears after an item has passed the pipeline
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && o_out.data.last |=> !o_out.valid || $past(w_load))
        else $error("output continued past last word without a new item");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS-1] && w_busy |-> !i_in.ready)
        else $error("input accepted while pipeline stalled");
    a_index0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_out.valid && o_out.data.key_index == 2'd0)
        else $error("new item did not start at key 0");
endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: four-key AES-128 encryptor check
// Sends plaintext blocks with four keys each, with random gaps and output
// stalls. It predicts the four ciphertexts with its own AES model and
// compares every result word against them in order.
// ----------------------------------------------------------------------------
module testbench;
    import a4k_pkg::*;

    localparam int RandItems = 350;
    localparam int CycleLimit = 400000;

    logic i_clk;
    logic i_rst_n;

    a4k_if #(.T(t_in_word))  in_ch ();
    a4k_if #(.T(t_out_word)) out_ch ();

    aes128_encrypt_four_keys_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // clock, period 4 ns
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    t_in_word  pending_words[$];
    t_out_word expected_cts[$];
    logic [7:0] sb_tab [256];
    int         errors;
    int         sent_words;
    int         got_words;
    int         cycles;
    int         send_gap;
    int         recv_gap;
    bit         stim_done;
    bit         hold_for_drain;
    int         drain_at;

    // S-box built from the GF(2^8) inverse and the affine map
    function automatic logic [7:0] mul2(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = mul2(a);
        end
        return p;
    endfunction

    task automatic build_sbox();
        logic [7:0] inv;
        logic [7:0] y;
        logic [7:0] aff_c;
        aff_c = 8'h63;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            for (int c = 1; c < 256; c++)
                if (gmul(x[7:0], c[7:0]) == 8'h01) inv = c[7:0];
            y = inv;
            for (int b = 0; b < 8; b++)
                y[b] = inv[b] ^ inv[(b+4)%8] ^ inv[(b+5)%8] ^ inv[(b+6)%8]
                       ^ inv[(b+7)%8] ^ aff_c[b];
            sb_tab[x] = y;
        end
    endtask

    // AES-128 encryption of one block, byte k at bits 8k+7:8k
    function automatic logic [127:0] aes_encrypt(input logic [127:0] pt,
                                                 input logic [127:0] key);
        logic [127:0] s;
        logic [127:0] t;
        logic [127:0] rk;
        logic [7:0]   rc;
        logic [7:0]   a0, a1, a2, a3, al;
        s  = pt ^ key;
        rk = key;
        rc = 8'h01;
        for (int rnd = 1; rnd <= 10; rnd++) begin
            // key schedule step
            rk[7:0]   ^= sb_tab[rk[111:104]] ^ rc;
            rk[15:8]  ^= sb_tab[rk[119:112]];
            rk[23:16] ^= sb_tab[rk[127:120]];
            rk[31:24] ^= sb_tab[rk[103:96]];
            for (int k = 4; k < 16; k++) rk[8*k +: 8] ^= rk[8*(k-4) +: 8];
            rc = mul2(rc);
            // SubBytes and ShiftRows
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    t[8*(r+4*c) +: 8] = sb_tab[s[8*(r+4*((c+r)&3)) +: 8]];
            s = t;
            if (rnd < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[32*c +: 8];
                    a1 = t[32*c+8 +: 8];
                    a2 = t[32*c+16 +: 8];
                    a3 = t[32*c+24 +: 8];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    s[32*c +: 8]    = a0 ^ al ^ mul2(a0 ^ a1);
                    s[32*c+8 +: 8]  = a1 ^ al ^ mul2(a1 ^ a2);
                    s[32*c+16 +: 8] = a2 ^ al ^ mul2(a2 ^ a3);
                    s[32*c+24 +: 8] = a3 ^ al ^ mul2(a3 ^ a0);
                end
            end
            s ^= rk;
        end
        return s;
    endfunction

    // four ciphertexts per accepted word, in key order
    task automatic predict_ciphertexts(input t_in_word w);
        logic [127:0] pt;
        logic [127:0] keys [4];
        logic [127:0] ct;
        t_out_word    o;
        pt      = {w.plaintext_hi, w.plaintext_lo};
        keys[0] = {w.key0_hi, w.key0_lo};
        keys[1] = {w.key1_hi, w.key1_lo};
        keys[2] = {w.key2_hi, w.key2_lo};
        keys[3] = {w.key3_hi, w.key3_lo};
        for (int i = 0; i < NumKeysDef; i++) begin
            ct = aes_encrypt(pt, keys[i]);
            o.key_index     = i[1:0];
            o.ciphertext_lo = ct[63:0];
            o.ciphertext_hi = ct[127:64];
            o.last          = (i == NumKeysDef - 1);
            expected_cts.push_back(o);
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // field value biased toward extremes
    function automatic logic [63:0] pick_field();
        case ($urandom_range(0, 9))
            0: return 64'h0;
            1: return '1;
            2: return 64'h1 << $urandom_range(0, 63);
            default: return rand64();
        endcase
    endfunction

    function automatic t_in_word make_word(input logic [63:0] v [10]);
        t_in_word w;
        w.plaintext_lo = v[0]; w.plaintext_hi = v[1];
        w.key0_lo = v[2]; w.key0_hi = v[3];
        w.key1_lo = v[4]; w.key1_hi = v[5];
        w.key2_lo = v[6]; w.key2_hi = v[7];
        w.key3_lo = v[8]; w.key3_hi = v[9];
        return w;
    endfunction

    // stimulus
    initial begin
        logic [63:0] v [10];
        errors = 0;
        build_sbox();
        // FIPS-197 vector in key slot 0, all zeros in slot 1, all ones in slot 2, zero lo / ones hi in slot 3
        v[0] = 64'h7766554433221100; v[1] = 64'hffeeddccbbaa9988;
        v[2] = 64'h0706050403020100; v[3] = 64'h0f0e0d0c0b0a0908;
        v[4] = 64'h0; v[5] = 64'h0; v[6] = '1; v[7] = '1;
        v[8] = 64'h0; v[9] = '1;
        pending_words.push_back(make_word(v));
        for (int i = 0; i < 10; i++) v[i] = 64'h0;
        pending_words.push_back(make_word(v));
        for (int i = 0; i < 10; i++) v[i] = '1;
        pending_words.push_back(make_word(v));
        // walking single bits across every field
        for (int b = 0; b < 16; b++) begin
            for (int i = 0; i < 10; i++) v[i] = 64'h1 << (b * 4 + i % 4);
            pending_words.push_back(make_word(v));
        end
        for (int b = 0; b < 3; b++) begin
            for (int i = 0; i < 10; i++) v[i] = 64'h8000000000000000 >> (b + i);
            pending_words.push_back(make_word(v));
        end
        for (int n = 0; n < RandItems; n++) begin
            for (int i = 0; i < 10; i++) v[i] = pick_field();
            pending_words.push_back(make_word(v));
        end
    end

    // reset, run limit and end of test
    initial begin
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && expected_cts.size() == 0);
        repeat (40) @(posedge i_clk);
        $display("Sent %0d plaintext words, checked %0d ciphertext words.",
                 sent_words, got_words);
        $display("Covered key extremes, walking bits, random data, stalls and a drain.");
        if (errors == 0 && expected_cts.size() == 0)
            $display("aes128_encrypt_four_keys_core test passed");
        else
            $display("aes128_encrypt_four_keys_core test failed");
        $finish;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("aes128_encrypt_four_keys_core test failed");
            $finish;
        end
    end

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid    <= 1'b0;
            in_ch.data     <= '0;
            send_gap       <= 0;
            sent_words     <= 0;
            stim_done      <= 1'b0;
            hold_for_drain <= 1'b0;
            drain_at       <= $urandom_range(40, 200);
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_ciphertexts(in_ch.data);
                sent_words <= sent_words + 1;
                send_gap   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
                if (sent_words + 1 == drain_at) hold_for_drain <= 1'b1;
            end
            if (in_ch.valid && !in_ch.ready) begin
                // keep the word steady
            end else if (hold_for_drain && !(in_ch.valid && in_ch.ready)) begin
                in_ch.valid <= 1'b0;
                if (expected_cts.size() == 0) hold_for_drain <= 1'b0;
            end else if (in_ch.valid && in_ch.ready && sent_words + 1 == drain_at) begin
                in_ch.valid <= 1'b0;
            end else if (send_gap > 0 && !(in_ch.valid && in_ch.ready)) begin
                in_ch.valid <= 1'b0;
                send_gap    <= send_gap - 1;
            end else if (in_ch.valid && in_ch.ready && $urandom_range(0, 1) == 0) begin
                in_ch.valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pending_words.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
                stim_done   <= 1'b1;
            end
        end
    end

    // output monitor and ready stalls
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_gap     <= 0;
            got_words    <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got_words <= got_words + 1;
                if (expected_cts.size() == 0) begin
                    $error("unexpected result word, key_index %0d", out_ch.data.key_index);
                    errors++;
                end else begin
                    exp_w = expected_cts.pop_front();
                    if (out_ch.data.key_index !== exp_w.key_index) begin
                        $error("key_index expected %0d actual %0d",
                               exp_w.key_index, out_ch.data.key_index);
                        errors++;
                    end
                    if (out_ch.data.ciphertext_lo !== exp_w.ciphertext_lo) begin
                        $error("ciphertext_lo expected %h actual %h",
                               exp_w.ciphertext_lo, out_ch.data.ciphertext_lo);
                        errors++;
                    end
                    if (out_ch.data.ciphertext_hi !== exp_w.ciphertext_hi) begin
                        $error("ciphertext_hi expected %h actual %h",
                               exp_w.ciphertext_hi, out_ch.data.ciphertext_hi);
                        errors++;
                    end
                    if (out_ch.data.last !== exp_w.last) begin
                        $error("last expected %0d actual %0d", exp_w.last, out_ch.data.last);
                        errors++;
                    end
                end
                recv_gap     <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
                out_ch.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap     <= recv_gap - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        cycles       = 0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
    end

endmodule
